// ===== design/pdts_pkg.sv =====
// pdts_pkg: shared constants, codes and control types of the priority delay task scheduler
// no dependencies; imported by every module of the block
`default_nettype none

package pdts_pkg;

  localparam int MaxTasks   = 16;
  localparam int CntW       = $clog2(MaxTasks + 1);
  localparam int IdxW       = $clog2(MaxTasks);
  localparam int IdW        = 8;
  localparam int PrioW      = 8;
  localparam int DelayW     = 16;
  localparam int TaskCountW = 5;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DELETE   = 2'd1,
    ACT_TICK     = 2'd2,
    ACT_SCHEDULE = 2'd3
  } act_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_IDLE      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic apply;
  } pdts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } pdts_sts_t;

endpackage

`default_nettype wire

// ===== design/pdts_ctrl.sv =====
// pdts_ctrl: request sequencer (idle, table scan, apply) and result valid flag
// depends on pdts_pkg
`default_nettype none

module pdts_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  input  wire pdts_pkg::pdts_sts_t sts_i,
  output pdts_pkg::pdts_cmd_t     cmd_o
);
  import pdts_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts_i.scan_done) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.step = !sts_i.scan_done;
      end
      ST_APPLY: begin
        cmd_o.apply = out_free;
      end
      default: ;
    endcase
  end

  // result register is only loaded once the previous result has gone
  assign out_valid_d = cmd_o.apply || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/pdts_dp.sv =====
// pdts_dp: task table cells, scan pointer, request and result registers
// depends on pdts_pkg; sequenced by pdts_ctrl
`default_nettype none

module pdts_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [1:0]                    action_i,
  input  wire logic [pdts_pkg::IdW-1:0]      task_id_i,
  input  wire logic [pdts_pkg::PrioW-1:0]    task_priority_i,
  input  wire logic [pdts_pkg::DelayW-1:0]   initial_delay_i,
  output logic [1:0]                         status_o,
  output logic [pdts_pkg::IdW-1:0]           selected_id_o,
  output logic [pdts_pkg::TaskCountW-1:0]    task_count_o,
  input  wire pdts_pkg::pdts_cmd_t           cmd_i,
  output pdts_pkg::pdts_sts_t                sts_o
);
  import pdts_pkg::*;

  // table, kept in priority order in slots 0 .. count-1
  logic [IdW-1:0]    id_q    [MaxTasks];
  logic [PrioW-1:0]  prio_q  [MaxTasks];
  logic [DelayW-1:0] delay_q [MaxTasks];
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   ptr_q;

  // latched request
  act_e              act_q;
  logic [IdW-1:0]    req_id_q;
  logic [PrioW-1:0]  req_prio_q;
  logic [DelayW-1:0] req_delay_q;

  // result register
  status_e           status_q, status_d;
  logic [IdW-1:0]    sel_q, sel_d;
  logic [CntW-1:0]   res_count_q;

  logic [IdxW-1:0]   rd_idx;
  logic [IdW-1:0]    rd_id;
  logic [PrioW-1:0]  rd_prio;
  logic [DelayW-1:0] rd_delay;
  logic              in_range;
  logic              full;
  logic              hit;

  assign rd_idx   = ptr_q[IdxW-1:0];
  assign rd_id    = id_q[rd_idx];
  assign rd_prio  = prio_q[rd_idx];
  assign rd_delay = delay_q[rd_idx];
  assign in_range = ptr_q < count_q;
  assign full     = count_q == CntW'(MaxTasks);

  always_comb begin
    case (act_q)
      ACT_INSERT:   hit = full || (rd_prio > req_prio_q);
      ACT_DELETE:   hit = rd_id == req_id_q;
      ACT_TICK:     hit = 1'b1;
      ACT_SCHEDULE: hit = rd_delay == '0;
      default:      hit = 1'b1;
    endcase
  end

  assign sts_o.scan_done = !in_range || hit;

  // outcome of the request at the point where the scan stopped
  always_comb begin
    status_d = STAT_OK;
    sel_d    = '0;
    count_d  = count_q;
    case (act_q)
      ACT_INSERT: begin
        if (full) status_d = STAT_FULL;
        else      count_d  = count_q + 1'b1;
      end
      ACT_DELETE: begin
        if (in_range) count_d  = count_q - 1'b1;
        else          status_d = STAT_NOT_FOUND;
      end
      ACT_TICK: ;
      ACT_SCHEDULE: begin
        if (in_range) sel_d    = rd_id;
        else          status_d = STAT_IDLE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ptr_q   <= '0;
    end else begin
      if (cmd_i.capture)   ptr_q <= '0;
      else if (cmd_i.step) ptr_q <= ptr_q + 1'b1;
      if (cmd_i.apply) count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q       <= act_e'(action_i);
      req_id_q    <= task_id_i;
      req_prio_q  <= task_priority_i;
      req_delay_q <= initial_delay_i;
    end
    if (cmd_i.apply) begin
      status_q    <= status_d;
      sel_q       <= sel_d;
      res_count_q <= count_d;
    end
  end

  // each cell loads from itself, its neighbours or the request
  for (genvar k = 0; k < MaxTasks; k++) begin : g_cell
    localparam int Prev = (k > 0) ? k - 1 : 0;
    localparam int Next = (k < MaxTasks - 1) ? k + 1 : k;
    localparam logic [CntW-1:0] KPos = CntW'(k);

    always_ff @(posedge clk_i) begin
      if (cmd_i.apply) begin
        case (act_q)
          ACT_INSERT: begin
            if (!full) begin
              if (KPos == ptr_q) begin
                id_q[k]    <= req_id_q;
                prio_q[k]  <= req_prio_q;
                delay_q[k] <= req_delay_q;
              end else if (k > 0 && KPos > ptr_q && KPos <= count_q) begin
                id_q[k]    <= id_q[Prev];
                prio_q[k]  <= prio_q[Prev];
                delay_q[k] <= delay_q[Prev];
              end
            end
          end
          ACT_DELETE: begin
            if (in_range && k < MaxTasks - 1 && KPos >= ptr_q) begin
              id_q[k]    <= id_q[Next];
              prio_q[k]  <= prio_q[Next];
              delay_q[k] <= delay_q[Next];
            end
          end
          ACT_TICK: begin
            if (delay_q[k] != '0) delay_q[k] <= delay_q[k] - 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  assign status_o      = status_q;
  assign selected_id_o = sel_q;
  assign task_count_o  = TaskCountW'(res_count_q);

endmodule

`default_nettype wire

// ===== design/priority_delay_task_scheduler.sv =====
// priority_delay_task_scheduler: one request at a time, table scanned one slot per cycle
// until the first match, then updated in the apply state once the result register is free
// a tick always stops its scan at slot 0; the other actions may scan all MaxTasks slots
// a new request is taken while the previous result is still stalled at the output register
// reset: table empty, no result pending; slot contents are only meaningful once written
`default_nettype none

module priority_delay_task_scheduler (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    action_i,
  input  wire logic [pdts_pkg::IdW-1:0]      task_id_i,
  input  wire logic [pdts_pkg::PrioW-1:0]    task_priority_i,
  input  wire logic [pdts_pkg::DelayW-1:0]   initial_delay_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         status_o,
  output logic [pdts_pkg::IdW-1:0]           selected_id_o,
  output logic [pdts_pkg::TaskCountW-1:0]    task_count_o
);
  import pdts_pkg::*;

  pdts_cmd_t cmd;
  pdts_sts_t sts;

  pdts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pdts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .task_id_i       (task_id_i),
    .task_priority_i (task_priority_i),
    .initial_delay_i (initial_delay_i),
    .status_o        (status_o),
    .selected_id_o   (selected_id_o),
    .task_count_o    (task_count_o),
    .cmd_i           (cmd),
    .sts_o           (sts)
  );

endmodule

`default_nettype wire

// ===== design/pdts_checker.sv =====
// pdts_checker: port-level checks on the scheduler, bound to the top level
// depends on pdts_pkg
`default_nettype none

module pdts_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [1:0]                    status_o,
  input wire logic [pdts_pkg::IdW-1:0]      selected_id_o,
  input wire logic [pdts_pkg::TaskCountW-1:0] task_count_o
);
  import pdts_pkg::*;

  // one request in flight: stalled right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while previous one still in progress");

  a_sel_only_on_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STAT_OK |-> selected_id_o == '0)
    else $error("selected id nonzero on a failed or non-schedule result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_FULL |-> task_count_o == TaskCountW'(MaxTasks))
    else $error("table full reported with a count below capacity");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(selected_id_o) && $stable(task_count_o))
    else $error("stalled result changed");

endmodule

bind priority_delay_task_scheduler pdts_checker u_pdts_checker (.*);

`default_nettype wire
